@@ hdl/periodic_timer_scheduler_assert.svh @@
// Assertion macros shared by the timer scheduler modules.
// The using module must have clk and rst_n in scope.
`ifndef PERIODIC_TIMER_SCHEDULER_ASSERT_SVH
`define PERIODIC_TIMER_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF

`define PTS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTS_ASSERT(lbl, cond, msg)

`define PTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/pts_pkg.sv @@
package pts_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 32;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SLOT_FLD_W = 4;
    localparam int PERIOD_W   = 31;
    localparam int TAG_W      = 16;
    localparam int MISSED_W   = 32;
    localparam int TW         = TIME_BITS + 1;   // signed countdown width
    // numerator of the missed-period divide: period - remaining, always positive
    localparam int NUM_W      = ((TIME_BITS > MISSED_W) ? TIME_BITS : MISSED_W) + 1;
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam logic signed [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic [PERIOD_W-1:0]  REM_MAX = {PERIOD_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_CREATE = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        NS_NONE     = 2'd0,
        NS_EXPIRED  = 2'd1,
        NS_WAITING  = 2'd2
    } next_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SUB_SCAN,
        S_FIRE_CHK,
        S_DIV,
        S_REARM,
        S_STAT_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic write_entry;
        logic scan_step;
        logic scan_sub;
        logic div_init;
        logic div_step;
        logic rearm;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic fire;
        logic div_last;
        logic out_free;
    } sts_t;

    // saturate a one-bit-wider time value to the countdown range
    function automatic logic signed [TW-1:0] sat_time(input logic signed [TW:0] v);
        logic signed [TW-1:0] r;
        if (v[TW] != v[TW-1])
            r = v[TW] ? TMIN : TMAX;
        else
            r = v[TW-1:0];
        return r;
    endfunction

endpackage

@@ hdl/periodic_timer_scheduler.sv @@
// Periodic timer scheduler: a 16-slot timer table driven by tick, create and delete items,
// one result per item. A tick subtracts elapsed from every armed slot and fires at most one
// expired slot (smallest remaining, lowest slot on a tie), reporting its tag and missed-period
// count, then re-arms it or disarms it if one-shot; every result also carries the next-timeout
// status. One item is worked at a time. Create and delete write the slot, then scan the table
// one slot per cycle for the status; a tick scans it once to subtract and find the minimum. A
// tick that fires adds a bit-serial restoring divide for the missed count, a re-arm step and a
// second status scan before its result is loaded. The result sits in an output
// register, so the next item is taken while the previous result waits to be read.
module periodic_timer_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       func,
    input  logic [pts_pkg::SLOT_FLD_W-1:0]   slot,
    input  logic [pts_pkg::PERIOD_W-1:0]     period,
    input  logic [pts_pkg::TAG_W-1:0]        target_tag,
    input  logic                             single_shot,
    input  logic [pts_pkg::PERIOD_W-1:0]     elapsed,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             fired,
    output logic [pts_pkg::SLOT_FLD_W-1:0]   fired_slot,
    output logic [pts_pkg::TAG_W-1:0]        fired_tag,
    output logic [pts_pkg::MISSED_W-1:0]     missed_count,
    output logic [1:0]                       next_status,
    output logic [pts_pkg::PERIOD_W-1:0]     next_remaining
);

    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .slot           (slot),
        .period         (period),
        .target_tag     (target_tag),
        .single_shot    (single_shot),
        .elapsed        (elapsed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fired          (fired),
        .fired_slot     (fired_slot),
        .fired_tag      (fired_tag),
        .missed_count   (missed_count),
        .next_status    (next_status),
        .next_remaining (next_remaining)
    );

endmodule

@@ hdl/pts_ctrl.sv @@
`include "periodic_timer_scheduler_assert.svh"

module pts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pts_pkg::sts_t sts,
    output pts_pkg::cmd_t cmd
);

    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    logic accept;

    assign in_stall = (state_reg != pts_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pts_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = sts.is_tick ? pts_pkg::S_SUB_SCAN : pts_pkg::S_WRITE;
            end
            pts_pkg::S_WRITE:
                state_next = pts_pkg::S_STAT_SCAN;
            pts_pkg::S_SUB_SCAN:
            begin
                if (sts.scan_last)
                    state_next = pts_pkg::S_FIRE_CHK;
            end
            pts_pkg::S_FIRE_CHK:
                state_next = sts.fire ? pts_pkg::S_DIV : pts_pkg::S_FINISH;
            pts_pkg::S_DIV:
            begin
                if (sts.div_last)
                    state_next = pts_pkg::S_REARM;
            end
            pts_pkg::S_REARM:
                state_next = pts_pkg::S_STAT_SCAN;
            pts_pkg::S_STAT_SCAN:
            begin
                if (sts.scan_last)
                    state_next = pts_pkg::S_FINISH;
            end
            pts_pkg::S_FINISH:
            begin
                if (sts.out_free)
                    state_next = pts_pkg::S_IDLE;
            end
            default:
                state_next = pts_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            pts_pkg::S_IDLE:
                cmd.load_item = accept;
            pts_pkg::S_WRITE:
                cmd.write_entry = 1'b1;
            pts_pkg::S_SUB_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_sub  = 1'b1;
            end
            pts_pkg::S_FIRE_CHK:
                cmd.div_init = sts.fire;
            pts_pkg::S_DIV:
                cmd.div_step = 1'b1;
            pts_pkg::S_REARM:
                cmd.rearm = 1'b1;
            pts_pkg::S_STAT_SCAN:
                cmd.scan_step = 1'b1;
            pts_pkg::S_FINISH:
                cmd.out_load = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    `PTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted but block not busy next cycle")
    `PTS_ASSERT(a_no_result_overwrite, !cmd.out_load || sts.out_free, "result loaded over an undelivered one")

endmodule

@@ hdl/pts_dp.sv @@
`include "periodic_timer_scheduler_assert.svh"

module pts_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pts_pkg::cmd_t                    cmd,
    output pts_pkg::sts_t                    sts,
    input  logic [1:0]                       func,
    input  logic [pts_pkg::SLOT_FLD_W-1:0]   slot,
    input  logic [pts_pkg::PERIOD_W-1:0]     period,
    input  logic [pts_pkg::TAG_W-1:0]        target_tag,
    input  logic                             single_shot,
    input  logic [pts_pkg::PERIOD_W-1:0]     elapsed,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             fired,
    output logic [pts_pkg::SLOT_FLD_W-1:0]   fired_slot,
    output logic [pts_pkg::TAG_W-1:0]        fired_tag,
    output logic [pts_pkg::MISSED_W-1:0]     missed_count,
    output logic [1:0]                       next_status,
    output logic [pts_pkg::PERIOD_W-1:0]     next_remaining
);

    // slot table
    logic [pts_pkg::SLOTS-1:0]       armed_reg;
    logic signed [pts_pkg::TW-1:0]   remaining_mem [pts_pkg::SLOTS];
    logic [pts_pkg::PERIOD_W-1:0]    reload_mem    [pts_pkg::SLOTS];
    logic [pts_pkg::TAG_W-1:0]       tag_mem       [pts_pkg::SLOTS];
    logic [pts_pkg::SLOTS-1:0]       oneshot_mem;

    // latched item
    logic [1:0]                      func_reg;
    logic [pts_pkg::SLOT_FLD_W-1:0]  slot_reg;
    logic [pts_pkg::PERIOD_W-1:0]    period_reg;
    logic [pts_pkg::TAG_W-1:0]       tag_reg;
    logic                            single_reg;
    logic [pts_pkg::PERIOD_W-1:0]    elapsed_reg;

    // min scan
    logic [pts_pkg::SLOT_W-1:0]      scan_idx_reg;
    logic                            best_vld_reg;
    logic signed [pts_pkg::TW-1:0]   best_val_reg;
    logic [pts_pkg::SLOT_W-1:0]      best_idx_reg;

    // restoring divider; num_reg ends up holding the quotient
    logic [pts_pkg::NUM_W-1:0]       num_reg;
    logic [pts_pkg::PERIOD_W-1:0]    drem_reg;
    logic [pts_pkg::PERIOD_W-1:0]    dvsr_reg;
    logic [pts_pkg::DCNT_W-1:0]      dcnt_reg;

    // fired info of the current item
    logic                            hit_reg;
    logic [pts_pkg::SLOT_FLD_W-1:0]  hit_slot_reg;
    logic [pts_pkg::TAG_W-1:0]       hit_tag_reg;
    logic [pts_pkg::MISSED_W-1:0]    hit_missed_reg;

    // result register
    logic                            out_valid_reg;
    logic                            o_fired_reg;
    logic [pts_pkg::SLOT_FLD_W-1:0]  o_slot_reg;
    logic [pts_pkg::TAG_W-1:0]       o_tag_reg;
    logic [pts_pkg::MISSED_W-1:0]    o_missed_reg;
    logic [1:0]                      o_status_reg;
    logic [pts_pkg::PERIOD_W-1:0]    o_nrem_reg;

    logic                            slot_ok;
    logic [pts_pkg::SLOT_W-1:0]      wr_idx;
    logic [pts_pkg::PERIOD_W-1:0]    period_eff;
    logic signed [pts_pkg::TW-1:0]   create_val;
    logic signed [pts_pkg::TW-1:0]   scan_cur;
    logic signed [pts_pkg::TW-1:0]   scan_new;
    logic                            scan_better;
    logic signed [pts_pkg::NUM_W:0]  div_num;
    logic [pts_pkg::PERIOD_W:0]      div_sh;
    logic                            div_ge;
    logic [pts_pkg::MISSED_W-1:0]    quot_sat;
    logic [1:0]                      status_now;
    logic [63:0]                     best_wide;
    logic [pts_pkg::PERIOD_W-1:0]    nrem_now;

    assign slot_ok    = (32'(slot_reg) < pts_pkg::SLOTS);
    assign wr_idx     = slot_reg[pts_pkg::SLOT_W-1:0];
    assign period_eff = (period_reg == '0) ? pts_pkg::PERIOD_W'(1) : period_reg;
    assign create_val = pts_pkg::sat_time($signed((pts_pkg::TW + 1)'(period_eff))
                                          + $signed((pts_pkg::TW + 1)'(elapsed_reg)));

    assign scan_cur   = remaining_mem[scan_idx_reg];
    assign scan_new   = cmd.scan_sub
                        ? pts_pkg::sat_time((pts_pkg::TW + 1)'(scan_cur)
                                            - $signed((pts_pkg::TW + 1)'(elapsed_reg)))
                        : scan_cur;
    // strict compare keeps the lowest slot on a tie
    assign scan_better = armed_reg[scan_idx_reg] && (!best_vld_reg || (scan_new < best_val_reg));

    assign div_num  = $signed((pts_pkg::NUM_W + 1)'(reload_mem[best_idx_reg]))
                      - (pts_pkg::NUM_W + 1)'(best_val_reg);
    assign div_sh   = {drem_reg, num_reg[pts_pkg::NUM_W-1]};
    assign div_ge   = (div_sh >= {1'b0, dvsr_reg});
    assign quot_sat = (num_reg[pts_pkg::NUM_W-1:pts_pkg::MISSED_W] != '0)
                      ? {pts_pkg::MISSED_W{1'b1}} : num_reg[pts_pkg::MISSED_W-1:0];

    assign best_wide = 64'(unsigned'(best_val_reg));
    assign nrem_now  = (best_wide > 64'(pts_pkg::REM_MAX))
                       ? pts_pkg::REM_MAX : best_wide[pts_pkg::PERIOD_W-1:0];

    always_comb
    begin
        if (!best_vld_reg)
            status_now = pts_pkg::NS_NONE;
        else if (best_val_reg <= 0)
            status_now = pts_pkg::NS_EXPIRED;
        else
            status_now = pts_pkg::NS_WAITING;
    end

    assign sts.is_tick   = (func == pts_pkg::FUNC_TICK);
    assign sts.scan_last = (scan_idx_reg == pts_pkg::SLOT_W'(pts_pkg::SLOTS - 1));
    assign sts.fire      = best_vld_reg && (best_val_reg <= 0);
    assign sts.div_last  = (dcnt_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= '0;
            scan_idx_reg  <= '0;
            best_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item || cmd.rearm)
            begin
                scan_idx_reg <= '0;
                best_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_better)
                    best_vld_reg <= 1'b1;
            end

            if (cmd.write_entry && slot_ok)
            begin
                if (func_reg == pts_pkg::FUNC_CREATE)
                    armed_reg[wr_idx] <= 1'b1;
                else if (func_reg == pts_pkg::FUNC_DELETE)
                    armed_reg[wr_idx] <= 1'b0;
            end
            else if (cmd.rearm && oneshot_mem[best_idx_reg])
                armed_reg[best_idx_reg] <= 1'b0;

            if (cmd.load_item)
                hit_reg <= 1'b0;
            else if (cmd.rearm)
                hit_reg <= 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg       <= func;
            slot_reg       <= slot;
            period_reg     <= period;
            tag_reg        <= target_tag;
            single_reg     <= single_shot;
            elapsed_reg    <= elapsed;
            hit_slot_reg   <= '0;
            hit_tag_reg    <= '0;
            hit_missed_reg <= '0;
        end

        if (cmd.write_entry && slot_ok && (func_reg == pts_pkg::FUNC_CREATE))
        begin
            remaining_mem[wr_idx] <= create_val;
            reload_mem[wr_idx]    <= period_eff;
            tag_mem[wr_idx]       <= tag_reg;
            oneshot_mem[wr_idx]   <= single_reg;
        end
        else if (cmd.scan_step && cmd.scan_sub && armed_reg[scan_idx_reg])
            remaining_mem[scan_idx_reg] <= scan_new;
        else if (cmd.rearm)
            remaining_mem[best_idx_reg] <= $signed(pts_pkg::TW'(reload_mem[best_idx_reg]));

        if (cmd.scan_step && scan_better)
        begin
            best_val_reg <= scan_new;
            best_idx_reg <= scan_idx_reg;
        end

        if (cmd.div_init)
        begin
            num_reg  <= div_num[pts_pkg::NUM_W-1:0];
            drem_reg <= '0;
            dvsr_reg <= reload_mem[best_idx_reg];
            dcnt_reg <= pts_pkg::DCNT_W'(pts_pkg::NUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            drem_reg <= div_ge ? pts_pkg::PERIOD_W'(div_sh - {1'b0, dvsr_reg})
                               : div_sh[pts_pkg::PERIOD_W-1:0];
            num_reg  <= {num_reg[pts_pkg::NUM_W-2:0], div_ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end

        if (cmd.rearm)
        begin
            hit_slot_reg   <= pts_pkg::SLOT_FLD_W'(best_idx_reg);
            hit_tag_reg    <= tag_mem[best_idx_reg];
            hit_missed_reg <= quot_sat;
        end

        if (cmd.out_load)
        begin
            o_fired_reg  <= hit_reg;
            o_slot_reg   <= hit_slot_reg;
            o_tag_reg    <= hit_tag_reg;
            o_missed_reg <= hit_missed_reg;
            o_status_reg <= status_now;
            o_nrem_reg   <= (status_now == pts_pkg::NS_WAITING) ? nrem_now : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fired          = o_fired_reg;
    assign fired_slot     = o_slot_reg;
    assign fired_tag      = o_tag_reg;
    assign missed_count   = o_missed_reg;
    assign next_status    = o_status_reg;
    assign next_remaining = o_nrem_reg;

    `PTS_ASSERT(a_wait_has_time, !out_valid || ((next_status == pts_pkg::NS_WAITING) == (next_remaining != '0)), "next_remaining disagrees with next_status")
    `PTS_ASSERT(a_idle_fields_zero, !out_valid || fired || ((fired_slot == '0) && (fired_tag == '0) && (missed_count == '0)), "fired fields set without a firing")

endmodule
